/* hw/rtl/mlfqs_pkg.sv */
// Shared constants, codes and controller/datapath interface types of the task table scheduler.
package mlfqs_pkg;

   localparam int SLOTS      = 64;
   localparam int SLOT_W     = $clog2(SLOTS);
   localparam int IDX_W      = SLOT_W + 1;
   localparam int ORDER_BITS = 16;
   localparam int ID_W       = 31;
   localparam int TICK_W     = 16;

   localparam logic [3:0] OP_ALLOC        = 4'd0;
   localparam logic [3:0] OP_SET_STATE    = 4'd1;
   localparam logic [3:0] OP_SET_PRIORITY = 4'd2;
   localparam logic [3:0] OP_YIELD        = 4'd3;
   localparam logic [3:0] OP_PICK         = 4'd4;
   localparam logic [3:0] OP_TICK         = 4'd5;
   localparam logic [3:0] OP_SET_LEVEL    = 4'd6;
   localparam logic [3:0] OP_LOCK         = 4'd7;
   localparam logic [3:0] OP_UNLOCK       = 4'd8;

   localparam logic [2:0] TS_UNUSED   = 3'd0;
   localparam logic [2:0] TS_EMBRYO   = 3'd1;
   localparam logic [2:0] TS_RUNNABLE = 3'd3;
   localparam logic [2:0] TS_RUNNING  = 3'd4;
   localparam logic [2:0] TS_MAX      = 3'd5;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_NONE    = 2'd1;
   localparam logic [1:0] STAT_BAD_PRI = 2'd2;
   localparam logic [1:0] STAT_REFUSED = 2'd3;

   localparam logic [1:0] LEVEL_TOP  = 2'd2;
   localparam logic [1:0] PRI_DEFLT  = 2'd3;
   localparam logic [3:0] PRI_MAX    = 4'd3;

   localparam logic CSR_BOOST_THRESHOLD = 1'b0;
   localparam logic CSR_LOCK_KEY        = 1'b1;

   localparam logic [TICK_W-1:0] THRESHOLD_RESET = TICK_W'(100);

   typedef enum logic [3:0] {
      CS_CLEAR,
      CS_IDLE,
      CS_DECODE,
      CS_READ,
      CS_EXEC,
      CS_SCAN,
      CS_BSCAN,
      CS_ROUND,
      CS_COMMIT,
      CS_FINISH
   } ctrl_state_type;

   typedef enum logic [1:0] {
      KIND_SINGLE,
      KIND_SCAN_READ,
      KIND_SCAN_COMMIT,
      KIND_PICK
   } op_kind_type;

   typedef struct packed {
      logic clear_step;
      logic capture;
      logic scan_init;
      logic scan_step;
      logic use_rank;
      logic boost_begin;
      logic round;
      logic commit;
      logic exec;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      op_kind_type kind;
      logic        boost_due;
      logic        scan_done;
      logic        have;
      logic        out_free;
      logic        clear_done;
   } sts_type;

endpackage

/* hw/rtl/mlfqs_ctrl.sv */
// Sequencing state machine of the task table scheduler.
module mlfqs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mlfqs_pkg::sts_type sts,
   output mlfqs_pkg::cmd_type cmd
);
   import mlfqs_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CS_CLEAR: begin
            if (sts.clear_done) state_in = CS_IDLE;
         end
         CS_IDLE: begin
            if (req_valid) state_in = CS_DECODE;
         end
         CS_DECODE: begin
            unique case (sts.kind)
               KIND_SINGLE:      state_in = CS_READ;
               KIND_SCAN_READ:   state_in = CS_SCAN;
               KIND_SCAN_COMMIT: state_in = CS_SCAN;
               KIND_PICK:        state_in = sts.boost_due ? CS_BSCAN : CS_SCAN;
               default:          state_in = CS_READ;
            endcase
         end
         CS_SCAN: begin
            if (sts.scan_done) begin
               state_in = (sts.kind == KIND_SCAN_READ) ? CS_READ : CS_COMMIT;
            end
         end
         CS_BSCAN: begin
            if (sts.scan_done) state_in = CS_ROUND;
         end
         CS_ROUND: begin
            state_in = sts.have ? CS_BSCAN : CS_SCAN;
         end
         CS_READ:   state_in = CS_EXEC;
         CS_EXEC:   state_in = CS_FINISH;
         CS_COMMIT: state_in = CS_FINISH;
         CS_FINISH: begin
            if (sts.out_free) state_in = CS_IDLE;
         end
         default: state_in = CS_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = (state_ff != CS_IDLE);
      unique case (state_ff)
         CS_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         CS_IDLE: begin
            cmd.capture = req_valid;
         end
         CS_DECODE: begin
            cmd.scan_init = (sts.kind != KIND_SINGLE);
            cmd.boost_begin = (sts.kind == KIND_PICK) && sts.boost_due;
         end
         CS_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         CS_BSCAN: begin
            cmd.scan_step = 1'b1;
            cmd.use_rank = 1'b1;
         end
         CS_ROUND: begin
            cmd.round = 1'b1;
            cmd.scan_init = 1'b1;
         end
         CS_READ: begin
         end
         CS_EXEC: begin
            cmd.exec = 1'b1;
         end
         CS_COMMIT: begin
            cmd.commit = 1'b1;
         end
         CS_FINISH: begin
            cmd.load_out = sts.out_free;
         end
         default: begin
         end
      endcase
   end

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == CS_DECODE))
      else $error("accepted transaction not decoded");

   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CS_FINISH && sts.out_free) |=> (state_ff == CS_IDLE))
      else $error("finished transaction did not release the block");

   a_round_rescan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CS_ROUND) |=> (state_ff == CS_BSCAN || state_ff == CS_SCAN))
      else $error("boost round did not restart a scan");

endmodule

/* hw/rtl/mlfqs_dpath.sv */
// Task table storage, slot scan, counters and result registers of the scheduler.
module mlfqs_dpath (
   input  logic                         clock,
   input  logic                         reset,
   input  mlfqs_pkg::cmd_type           cmd,
   output mlfqs_pkg::sts_type           sts,
   input  logic [3:0]                   req_opcode,
   input  logic [5:0]                   req_slot,
   input  logic [30:0]                  req_task_id,
   input  logic [2:0]                   req_new_state,
   input  logic [1:0]                   req_new_level,
   input  logic signed [3:0]            req_priority_value,
   input  logic [31:0]                  req_key,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [31:0]                  csr_wdata,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic [5:0]                   rsp_chosen_slot,
   output logic [30:0]                  rsp_chosen_id,
   output logic [1:0]                   rsp_chosen_level,
   output logic                         rsp_boosted
);
   import mlfqs_pkg::*;

   logic [TICK_W-1:0] thr_ff;
   logic [31:0]       key_cfg_ff;

   logic [3:0]        op_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [ID_W-1:0]   tid_ff;
   logic [2:0]        nst_ff;
   logic [1:0]        nlv_ff;
   logic [3:0]        pr_ff;
   logic [31:0]       key_ff;

   logic [2:0]            st_mem  [SLOTS];
   logic                  lk_mem  [SLOTS];
   logic                  rk_mem  [SLOTS];
   logic [ID_W-1:0]       id_mem  [SLOTS];
   logic [1:0]            lvl_mem [SLOTS];
   logic [1:0]            pri_mem [SLOTS];
   logic [ORDER_BITS-1:0] ord_mem [SLOTS];

   logic [2:0]            rd_st_ff;
   logic                  rd_lk_ff;
   logic                  rd_rk_ff;
   logic [ID_W-1:0]       rd_id_ff;
   logic [1:0]            rd_lvl_ff;
   logic [1:0]            rd_pri_ff;
   logic [ORDER_BITS-1:0] rd_ord_ff;

   logic [IDX_W-1:0]  idx_ff;
   logic [SLOT_W-1:0] pidx_ff;
   logic              pval_ff;
   logic [IDX_W-1:0]  clr_ff;
   logic              first_ff;

   logic                  have_ff, blocked_ff, held_ff;
   logic [SLOT_W-1:0]     best_idx_ff;
   logic [ID_W-1:0]       best_id_ff;
   logic [1:0]            best_lvl_ff;
   logic [1:0]            best_pri_ff;
   logic [ORDER_BITS-1:0] best_ord_ff;

   logic [ID_W-1:0]       next_id_ff;
   logic [ORDER_BITS-1:0] lno_ff [3];
   logic [TICK_W-1:0]     tick_ff;
   logic [IDX_W-1:0]      rank_n_ff;
   logic                  boosted_ff;

   logic [1:0]        res_status_ff;
   logic [SLOT_W-1:0] res_slot_ff;
   logic [ID_W-1:0]   res_id_ff;
   logic [1:0]        res_lvl_ff;
   logic              res_bst_ff;

   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic [ID_W-1:0]   rsp_id_ff;
   logic [1:0]        rsp_lvl_ff;
   logic              rsp_bst_ff;

   // scan evaluation
   logic [SLOT_W-1:0] rd_addr;
   logic [2:0]        cur_st;
   logic              cur_lk, cur_rk, eval, beats, take, set_block, held_set, cand;
   logic              eff_rank;

   // table update controls
   logic [SLOT_W-1:0]     waddr;
   logic [SLOT_W-1:0]     tw_addr;
   logic                  clear_en;
   logic                  rk_we, rk_wd, rk_clear;
   logic [SLOT_W-1:0]     rk_addr;
   logic                  id_we, lvl_we, pri_we, ord_we, st_we, lk_we;
   logic [ID_W-1:0]       id_wd;
   logic [1:0]            lvl_wd, pri_wd;
   logic [ORDER_BITS-1:0] ord_wd;
   logic [2:0]            st_wd;
   logic                  lk_wd;
   logic                  lno_take, boost_end, tick_clear, tick_inc, next_id_inc;
   logic [1:0]            lno_sel;
   logic                  rank_set;
   logic                  res_load;
   logic [1:0]            res_status;
   logic [SLOT_W-1:0]     res_slot;
   logic [ID_W-1:0]       res_id;
   logic [1:0]            res_lvl;
   logic                  res_bst;
   logic                  addressed, in_range, key_ok;
   logic [1:0]            sat_lvl;

   assign rd_addr  = cmd.scan_step ? idx_ff[SLOT_W-1:0] : slot_ff;
   assign cur_st   = rd_st_ff;
   assign cur_lk   = rd_lk_ff;
   assign cur_rk   = rd_rk_ff;
   assign eval     = cmd.scan_step && pval_ff;
   assign eff_rank = cmd.use_rank && !first_ff;

   // first boost round clears the rank marks as it reads them
   assign clear_en = cmd.clear_step && !clr_ff[SLOT_W];
   assign tw_addr  = clear_en ? clr_ff[SLOT_W-1:0] : waddr;
   assign rk_clear = cmd.scan_step && cmd.use_rank && first_ff && !idx_ff[SLOT_W];
   assign rk_we    = rank_set || rk_clear;
   assign rk_wd    = rank_set;
   assign rk_addr  = rank_set ? best_idx_ff : idx_ff[SLOT_W-1:0];

   assign addressed = (op_ff == OP_SET_STATE) || (op_ff == OP_YIELD) ||
                      (op_ff == OP_SET_LEVEL) || (op_ff == OP_LOCK) || (op_ff == OP_UNLOCK);
   assign in_range  = {1'b0, slot_ff} < IDX_W'(SLOTS);
   assign key_ok    = (key_ff == key_cfg_ff);
   assign sat_lvl   = (nlv_ff > LEVEL_TOP) ? LEVEL_TOP : nlv_ff;

   always_comb begin
      if (rd_lvl_ff != best_lvl_ff) begin
         beats = rd_lvl_ff < best_lvl_ff;
      end else if (rd_lvl_ff == LEVEL_TOP && rd_pri_ff != best_pri_ff) begin
         beats = rd_pri_ff < best_pri_ff;
      end else begin
         beats = rd_ord_ff < best_ord_ff;
      end
   end

   always_comb begin
      take = 1'b0;
      set_block = 1'b0;
      held_set = 1'b0;
      cand = 1'b0;
      case (op_ff)
         OP_ALLOC: begin
            take = eval && !have_ff && (cur_st == TS_UNUSED);
         end
         OP_SET_PRIORITY: begin
            take = eval && !have_ff && (cur_st != TS_UNUSED) && (rd_id_ff == tid_ff);
         end
         OP_PICK: begin
            cand = eval && (cur_st == TS_RUNNABLE) && !(eff_rank && cur_rk) && !blocked_ff;
            take = cand && (cur_lk || !have_ff || beats);
            set_block = cand && cur_lk;
         end
         OP_LOCK: begin
            held_set = eval && cur_lk && ((cur_st == TS_RUNNABLE) || (cur_st == TS_RUNNING));
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      sts.kind = KIND_SINGLE;
      case (op_ff)
         OP_ALLOC:        sts.kind = KIND_SCAN_COMMIT;
         OP_SET_PRIORITY: sts.kind = (pr_ff > PRI_MAX) ? KIND_SINGLE : KIND_SCAN_COMMIT;
         OP_PICK:         sts.kind = KIND_PICK;
         OP_LOCK:         sts.kind = (in_range && key_ok) ? KIND_SCAN_READ : KIND_SINGLE;
         default:         sts.kind = KIND_SINGLE;
      endcase
      sts.boost_due  = (tick_ff >= thr_ff);
      sts.scan_done  = pval_ff && (pidx_ff == SLOT_W'(SLOTS - 1));
      sts.have       = have_ff;
      sts.out_free   = !rsp_valid_ff || !rsp_stall;
      sts.clear_done = clr_ff[SLOT_W];
   end

   always_comb begin
      waddr = cmd.exec ? slot_ff : best_idx_ff;
      id_we = 1'b0; lvl_we = 1'b0; pri_we = 1'b0; ord_we = 1'b0; st_we = 1'b0; lk_we = 1'b0;
      id_wd = next_id_ff;
      lvl_wd = 2'd0;
      pri_wd = PRI_DEFLT;
      ord_wd = '0;
      st_wd = TS_UNUSED;
      lk_wd = 1'b0;
      lno_take = 1'b0; lno_sel = 2'd0; boost_end = 1'b0;
      tick_clear = 1'b0; tick_inc = 1'b0; next_id_inc = 1'b0; rank_set = 1'b0;
      res_load = cmd.exec || cmd.commit;
      res_status = STAT_OK;
      res_slot = '0;
      res_id = '0;
      res_lvl = 2'd0;
      res_bst = 1'b0;
      if (cmd.exec) begin
         if (addressed) begin
            res_slot = slot_ff;
            res_lvl = rd_lvl_ff;
         end
         if (addressed && !in_range) begin
            res_status = STAT_NONE;
            res_lvl = 2'd0;
         end else begin
            case (op_ff)
               OP_SET_STATE: begin
                  if (nst_ff > TS_MAX) begin
                     res_status = STAT_NONE;
                  end else begin
                     st_we = 1'b1;
                     st_wd = nst_ff;
                  end
               end
               OP_SET_PRIORITY: begin
                  res_status = STAT_BAD_PRI;
               end
               OP_YIELD: begin
                  if (rd_st_ff == TS_UNUSED) begin
                     res_status = STAT_NONE;
                  end else begin
                     if (rd_lvl_ff < LEVEL_TOP) begin
                        ord_we = 1'b1;
                        lno_sel = rd_lvl_ff;
                        ord_wd = lno_ff[rd_lvl_ff];
                        lno_take = 1'b1;
                     end
                     st_we = 1'b1;
                     st_wd = TS_RUNNABLE;
                  end
               end
               OP_TICK: begin
                  tick_inc = 1'b1;
               end
               OP_SET_LEVEL: begin
                  lvl_we = 1'b1;
                  lvl_wd = sat_lvl;
                  res_lvl = sat_lvl;
               end
               OP_LOCK: begin
                  if (!key_ok || held_ff) begin
                     res_status = STAT_REFUSED;
                  end else begin
                     lk_we = 1'b1;
                     lk_wd = 1'b1;
                     tick_clear = 1'b1;
                  end
               end
               OP_UNLOCK: begin
                  if (!key_ok || !rd_lk_ff) begin
                     res_status = STAT_REFUSED;
                  end else begin
                     lk_we = 1'b1;
                     lvl_we = 1'b1;
                     pri_we = 1'b1;
                     ord_we = 1'b1;
                     res_lvl = 2'd0;
                  end
               end
               default: begin
               end
            endcase
         end
      end else if (cmd.commit) begin
         case (op_ff)
            OP_ALLOC: begin
               if (have_ff) begin
                  st_we = 1'b1;
                  st_wd = TS_EMBRYO;
                  id_we = 1'b1;
                  lvl_we = 1'b1;
                  pri_we = 1'b1;
                  ord_we = 1'b1;
                  ord_wd = lno_ff[0];
                  lno_take = 1'b1;
                  lk_we = 1'b1;
                  next_id_inc = 1'b1;
                  res_slot = best_idx_ff;
                  res_id = next_id_ff;
               end else begin
                  res_status = STAT_NONE;
               end
            end
            OP_SET_PRIORITY: begin
               if (have_ff) begin
                  pri_we = 1'b1;
                  pri_wd = pr_ff[1:0];
                  res_slot = best_idx_ff;
                  res_id = best_id_ff;
                  res_lvl = best_lvl_ff;
               end else begin
                  res_status = STAT_NONE;
               end
            end
            OP_PICK: begin
               res_bst = boosted_ff;
               if (have_ff) begin
                  st_we = 1'b1;
                  st_wd = TS_RUNNING;
                  res_slot = best_idx_ff;
                  res_id = best_id_ff;
                  res_lvl = best_lvl_ff;
               end else begin
                  res_status = STAT_NONE;
               end
            end
            default: begin
            end
         endcase
      end else if (cmd.round) begin
         if (have_ff) begin
            lk_we = 1'b1;
            rank_set = 1'b1;
            lvl_we = 1'b1;
            pri_we = 1'b1;
            ord_we = 1'b1;
            ord_wd = ORDER_BITS'(rank_n_ff + IDX_W'(1));
         end else begin
            boost_end = 1'b1;
         end
      end
   end

   // configuration, request capture and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESHOLD_RESET;
         key_cfg_ff <= '0;
         clr_ff <= '0;
         first_ff <= 1'b0;
         next_id_ff <= ID_W'(1);
         for (int i = 0; i < 3; i++) begin
            lno_ff[i] <= ORDER_BITS'(1);
         end
         tick_ff <= '0;
         rank_n_ff <= '0;
         boosted_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_BOOST_THRESHOLD) thr_ff <= csr_wdata[TICK_W-1:0];
            if (csr_index == CSR_LOCK_KEY) key_cfg_ff <= csr_wdata;
         end
         if (clear_en) clr_ff <= clr_ff + IDX_W'(1);
         if (cmd.boost_begin) begin
            first_ff <= 1'b1;
         end else if (cmd.round) begin
            first_ff <= 1'b0;
         end
         if (cmd.boost_begin) begin
            rank_n_ff <= '0;
            boosted_ff <= 1'b1;
         end else if (rank_set) begin
            rank_n_ff <= rank_n_ff + IDX_W'(1);
         end
         if (cmd.capture) boosted_ff <= 1'b0;
         if (next_id_inc) next_id_ff <= next_id_ff + ID_W'(1);
         if (boost_end) begin
            lno_ff[0] <= ORDER_BITS'(rank_n_ff + IDX_W'(1));
            lno_ff[1] <= ORDER_BITS'(1);
            lno_ff[2] <= ORDER_BITS'(1);
         end else if (lno_take) begin
            lno_ff[lno_sel] <= lno_ff[lno_sel] + ORDER_BITS'(1);
         end
         if (tick_clear || boost_end) begin
            tick_ff <= '0;
         end else if (tick_inc && tick_ff != '1) begin
            tick_ff <= tick_ff + TICK_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= req_opcode;
         slot_ff <= req_slot;
         tid_ff <= req_task_id;
         nst_ff <= req_new_state;
         nlv_ff <= req_new_level;
         pr_ff <= req_priority_value;
         key_ff <= req_key;
      end
   end

   // slot table memories, one registered read port
   always_ff @(posedge clock) begin
      if (st_we || clear_en) st_mem[tw_addr] <= clear_en ? TS_UNUSED : st_wd;
      if (lk_we || clear_en) lk_mem[tw_addr] <= clear_en ? 1'b0 : lk_wd;
      if (rk_we) rk_mem[rk_addr] <= rk_wd;
      if (id_we) id_mem[waddr] <= id_wd;
      if (lvl_we) lvl_mem[waddr] <= lvl_wd;
      if (pri_we) pri_mem[waddr] <= pri_wd;
      if (ord_we) ord_mem[waddr] <= ord_wd;
      rd_st_ff <= st_mem[rd_addr];
      rd_lk_ff <= lk_mem[rd_addr];
      rd_rk_ff <= rk_mem[rd_addr];
      rd_id_ff <= id_mem[rd_addr];
      rd_lvl_ff <= lvl_mem[rd_addr];
      rd_pri_ff <= pri_mem[rd_addr];
      rd_ord_ff <= ord_mem[rd_addr];
   end

   // scan sequencing and best candidate
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         pval_ff <= 1'b0;
         have_ff <= 1'b0;
         blocked_ff <= 1'b0;
         held_ff <= 1'b0;
      end else if (cmd.scan_init) begin
         idx_ff <= '0;
         pval_ff <= 1'b0;
         have_ff <= 1'b0;
         blocked_ff <= 1'b0;
         held_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         if (idx_ff < IDX_W'(SLOTS)) begin
            pval_ff <= 1'b1;
            idx_ff <= idx_ff + IDX_W'(1);
         end else begin
            pval_ff <= 1'b0;
         end
         if (take) have_ff <= 1'b1;
         if (set_block) blocked_ff <= 1'b1;
         if (held_set) held_ff <= 1'b1;
      end else begin
         pval_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff <= idx_ff[SLOT_W-1:0];
      if (take) begin
         best_idx_ff <= pidx_ff;
         best_id_ff <= rd_id_ff;
         best_lvl_ff <= rd_lvl_ff;
         best_pri_ff <= rd_pri_ff;
         best_ord_ff <= rd_ord_ff;
      end
   end

   // result and output registers
   always_ff @(posedge clock) begin
      if (res_load) begin
         res_status_ff <= res_status;
         res_slot_ff <= res_slot;
         res_id_ff <= res_id;
         res_lvl_ff <= res_lvl;
         res_bst_ff <= res_bst;
      end
      if (cmd.load_out) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff <= res_slot_ff;
         rsp_id_ff <= res_id_ff;
         rsp_lvl_ff <= res_lvl_ff;
         rsp_bst_ff <= res_bst_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_chosen_slot  = rsp_slot_ff;
   assign rsp_chosen_id    = rsp_id_ff;
   assign rsp_chosen_level = rsp_lvl_ff;
   assign rsp_boosted      = rsp_bst_ff;

   a_scan_init: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_init |=> (idx_ff == '0 && !have_ff && !pval_ff))
      else $error("scan did not restart cleanly");

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("loaded result not presented");

   a_rank_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.round && have_ff) |=> (rank_n_ff == $past(rank_n_ff) + IDX_W'(1)))
      else $error("boost round did not count its slot");

endmodule

/* hw/rtl/mlfq_task_table_scheduler_core.sv */
// Top level of the three-level feedback queue task table scheduler.
// One-slot ops, tick and refused requests read the addressed slot, then execute.
// Alloc, set_priority and pick scan all slots, then commit; a good-key lock scans first.
// A boosting pick runs one ranking scan per runnable task plus one more before its scan.
// One transaction at a time; the next is accepted once the result is loaded for output.
// Sync reset; a clearing pass marks every slot unused and unlocked, input stalled.
module mlfq_task_table_scheduler_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [3:0]        req_opcode,
   input  logic [5:0]        req_slot,
   input  logic [30:0]       req_task_id,
   input  logic [2:0]        req_new_state,
   input  logic [1:0]        req_new_level,
   input  logic signed [3:0] req_priority_value,
   input  logic [31:0]       req_key,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [31:0]       csr_wdata,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [5:0]        rsp_chosen_slot,
   output logic [30:0]       rsp_chosen_id,
   output logic [1:0]        rsp_chosen_level,
   output logic              rsp_boosted
);
   import mlfqs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   mlfqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   mlfqs_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_opcode         (req_opcode),
      .req_slot           (req_slot),
      .req_task_id        (req_task_id),
      .req_new_state      (req_new_state),
      .req_new_level      (req_new_level),
      .req_priority_value (req_priority_value),
      .req_key            (req_key),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_chosen_slot    (rsp_chosen_slot),
      .rsp_chosen_id      (rsp_chosen_id),
      .rsp_chosen_level   (rsp_chosen_level),
      .rsp_boosted        (rsp_boosted)
   );

endmodule
